[rtl/clns_pkg.sv]
// Shared types, constants and lookup functions for the character LCD nibble sequencer.
// Used by clns_front, clns_queue, clns_back and char_lcd_nibble_sequencer_top.
package clns_pkg;

   // Field widths.
   localparam int TimeWidth   = 15;
   localparam int KindWidth   = 3;
   localparam int CsrIdxWidth = 2;
   localparam int QueueDepth  = 4;
   localparam int QueuePtrW   = $clog2(QueueDepth);

   // Request kinds.
   localparam logic [KindWidth-1:0] KindCommand = 3'd0;
   localparam logic [KindWidth-1:0] KindData    = 3'd1;
   localparam logic [KindWidth-1:0] KindCursor  = 3'd2;
   localparam logic [KindWidth-1:0] KindInit    = 3'd3;
   localparam logic [KindWidth-1:0] KindClear   = 3'd4;

   // Configuration register indexes.
   localparam logic [CsrIdxWidth-1:0] CsrCommandPulse = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrDataPulse    = 2'd1;

   // Reset values of the pulse width registers.
   localparam logic [TimeWidth-1:0] CommandPulseReset = 15'd2000;
   localparam logic [TimeWidth-1:0] DataPulseReset    = 15'd40;

   // Timing constants in microseconds.
   localparam logic [TimeWidth-1:0] InitLeadUs    = 15'd20000;
   localparam logic [TimeWidth-1:0] SettleFirstUs  = 15'd5000;
   localparam logic [TimeWidth-1:0] SettleSecondUs = 15'd11000;
   localparam logic [TimeWidth-1:0] ClearSettleUs  = 15'd2000;

   // Command bytes.
   localparam logic [7:0] CmdLine1Base = 8'h80;
   localparam logic [7:0] CmdLine2Base = 8'hC0;
   localparam logic [7:0] CmdClear     = 8'h01;

   // One classified request as it travels from the front to the back.
   typedef struct packed {
      logic       is_init;
      logic       is_data;
      logic       clear_settle;
      logic [7:0] byte_value;
   } desc_type;

   // Command bytes of the power-on init sequence.
   function automatic logic [7:0] init_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0: b = 8'h03;
         3'd1: b = 8'h03;
         3'd2: b = 8'h03;
         3'd3: b = 8'h02;
         3'd4: b = 8'h28;
         3'd5: b = 8'h0C;
         3'd6: b = 8'h06;
         3'd7: b = 8'h01;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Settle time after the low nibble of each init byte.
   function automatic logic [TimeWidth-1:0] init_settle(input logic [2:0] idx);
      logic [TimeWidth-1:0] t;
      case (idx)
         3'd0: t = SettleFirstUs;
         3'd1: t = SettleSecondUs;
         3'd7: t = ClearSettleUs;
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

[rtl/clns_front.sv]
// Front end: accepts requests and classifies them into byte descriptors.
// Depends on clns_pkg; feeds clns_queue.
module clns_front (
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [clns_pkg::KindWidth-1:0]   req_kind,
   input  logic [7:0]                       req_byte_value,
   input  logic [7:0]                       req_row,
   input  logic [7:0]                       req_column,
   input  logic                             q_full,
   output logic                             q_push,
   output clns_pkg::desc_type               q_wdata
);

   logic [7:0] cursor_addr;
   logic       known_kind;

   // Cursor address for rows one and two; any other row homes the cursor.
   always_comb begin
      if (req_row == 8'd1) begin
         cursor_addr = clns_pkg::CmdLine1Base + req_column - 8'd1;
      end else if (req_row == 8'd2) begin
         cursor_addr = clns_pkg::CmdLine2Base + req_column - 8'd1;
      end else begin
         cursor_addr = clns_pkg::CmdLine1Base;
      end
   end

   // Classify the request into a descriptor.
   always_comb begin
      q_wdata    = '0;
      known_kind = 1'b1;
      case (req_kind)
         clns_pkg::KindCommand: begin
            q_wdata.byte_value = req_byte_value;
         end
         clns_pkg::KindData: begin
            q_wdata.is_data    = 1'b1;
            q_wdata.byte_value = req_byte_value;
         end
         clns_pkg::KindCursor: begin
            q_wdata.byte_value = cursor_addr;
         end
         clns_pkg::KindInit: begin
            q_wdata.is_init = 1'b1;
         end
         clns_pkg::KindClear: begin
            q_wdata.clear_settle = 1'b1;
            q_wdata.byte_value   = clns_pkg::CmdClear;
         end
         default: begin
            known_kind = 1'b0;
         end
      endcase
   end

   // Unknown kinds are accepted and dropped without producing pulses.
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full && known_kind;

endmodule

[rtl/clns_queue.sv]
// Short descriptor queue between the front and the back.
// Depends on clns_pkg for the descriptor type and depth.
module clns_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  clns_pkg::desc_type wdata,
   output logic               full,
   input  logic               pop,
   output logic               rvalid,
   output clns_pkg::desc_type rdata
);

   localparam int CountWidth = clns_pkg::QueuePtrW + 1;

   clns_pkg::desc_type                 store_ff [clns_pkg::QueueDepth];
   logic [clns_pkg::QueuePtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [clns_pkg::QueuePtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]              count_ff, count_in;
   logic                               do_push;
   logic                               do_pop;

   assign full    = (count_ff == CountWidth'(clns_pkg::QueueDepth));
   assign rvalid  = (count_ff != '0);
   assign rdata   = store_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && rvalid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[rtl/clns_back.sv]
// Back end: walks each descriptor, one enable pulse beat per cycle while unstalled.
// Depends on clns_pkg; drains clns_queue and drives the rsp_ output register.
module clns_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  clns_pkg::desc_type                  q_rdata,
   output logic                                q_pop,
   input  logic [clns_pkg::TimeWidth-1:0]      command_pulse_us,
   input  logic [clns_pkg::TimeWidth-1:0]      data_pulse_us,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [clns_pkg::TimeWidth-1:0]      rsp_wait_before_us,
   output logic                                rsp_register_select,
   output logic [3:0]                          rsp_nibble,
   output logic [clns_pkg::TimeWidth-1:0]      rsp_pulse_us,
   output logic [clns_pkg::TimeWidth-1:0]      rsp_wait_after_us,
   output logic                                rsp_last
);

   clns_pkg::desc_type              cur_ff, cur_in;
   logic                            active_ff, active_in;
   logic [3:0]                      cnt_ff, cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [clns_pkg::TimeWidth-1:0]  wait_before_ff, wait_after_ff, pulse_ff;
   logic                            rs_ff, last_ff;
   logic [3:0]                      nibble_ff;

   logic                            out_free;
   logic                            last_pulse;
   logic                            finish;
   logic                            load;
   logic [7:0]                      cur_byte;
   logic [3:0]                      gen_nibble;
   logic [clns_pkg::TimeWidth-1:0]  gen_wait_before;
   logic [clns_pkg::TimeWidth-1:0]  gen_wait_after;
   logic [clns_pkg::TimeWidth-1:0]  gen_pulse;

   // Pulse fields for beat cnt_ff of the current descriptor.
   always_comb begin
      cur_byte   = cur_ff.is_init ? clns_pkg::init_byte(cnt_ff[3:1]) : cur_ff.byte_value;
      gen_nibble = cnt_ff[0] ? cur_byte[3:0] : cur_byte[7:4];
      gen_pulse  = cur_ff.is_data ? data_pulse_us : command_pulse_us;
      gen_wait_before = (cur_ff.is_init && cnt_ff == 4'd0) ? clns_pkg::InitLeadUs : '0;
      gen_wait_after  = '0;
      if (cnt_ff[0]) begin
         if (cur_ff.is_init) begin
            gen_wait_after = clns_pkg::init_settle(cnt_ff[3:1]);
         end else if (cur_ff.clear_settle) begin
            gen_wait_after = clns_pkg::ClearSettleUs;
         end
      end
      last_pulse = cur_ff.is_init ? (cnt_ff == 4'd15) : (cnt_ff == 4'd1);
   end

   // Sequencing: the next descriptor loads in the cycle the last beat leaves.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign finish   = active_ff && out_free && last_pulse;
   assign load     = q_valid && (!active_ff || finish);
   assign q_pop    = load;

   always_comb begin
      cur_in       = load ? q_rdata : cur_ff;
      active_in    = active_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         active_in = 1'b1;
         cnt_in    = '0;
      end else if (finish) begin
         active_in = 1'b0;
         cnt_in    = '0;
      end else if (active_ff && out_free) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (out_free) begin
         rsp_valid_in = active_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: descriptor and output beat.
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (active_ff && out_free) begin
         wait_before_ff <= gen_wait_before;
         rs_ff          <= cur_ff.is_data;
         nibble_ff      <= gen_nibble;
         pulse_ff       <= gen_pulse;
         wait_after_ff  <= gen_wait_after;
         last_ff        <= last_pulse;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_wait_before_us  = wait_before_ff;
   assign rsp_register_select = rs_ff;
   assign rsp_nibble          = nibble_ff;
   assign rsp_pulse_us        = pulse_ff;
   assign rsp_wait_after_us   = wait_after_ff;
   assign rsp_last            = last_ff;

   // A byte request never runs past its second beat.
   assert property (@(posedge clock) disable iff (reset)
      active_ff && !cur_ff.is_init |-> cnt_ff <= 4'd1)
      else $error("byte descriptor beat counter overran");

   // The beat counter rests at zero while no descriptor is active.
   assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> cnt_ff == 4'd0)
      else $error("beat counter not cleared while idle");

   // The lead wait only precedes the first init nibble, a command nibble of zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && wait_before_ff != '0 |-> nibble_ff == 4'd0 && !rs_ff && !last_ff)
      else $error("lead wait on an unexpected beat");

endmodule

[rtl/char_lcd_nibble_sequencer_top.sv]
// Top level of the character LCD nibble sequencer: configuration registers and
// the front, queue and back instances. Depends on clns_pkg and all clns_ modules.
//
// Usage:
//   The req_ channel takes one request per beat (command, character, cursor
//   move, init or clear). The rsp_ channel gives one enable pulse beat per
//   cycle while rsp_stall is low: two beats for a byte request, sixteen for
//   init, none for an unknown kind. rsp_last marks the final beat of a request.
//   The csr_ channel writes the command and character pulse widths; it is
//   always ready. The user makes writes only while the block is idle; the
//   block itself does not enforce this.
// An accepted request passes the queue, the back end's descriptor register
//   and its output register before its first beat appears.
// Throughput: one beat per cycle while rsp_stall is low; a four-entry
//   descriptor queue lets requests be taken while the back end is busy.
// Reset: the queue empties, rsp_valid drops and the pulse widths return
//   to 2000 us for commands and 40 us for characters.
// Stall: when rsp_stall is high the output beat holds; once the queue is
//   full, req_stall rises until the back end frees an entry.
module char_lcd_nibble_sequencer_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [clns_pkg::KindWidth-1:0]       req_kind,
   input  logic [7:0]                           req_byte_value,
   input  logic [7:0]                           req_row,
   input  logic [7:0]                           req_column,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [clns_pkg::TimeWidth-1:0]       rsp_wait_before_us,
   output logic                                 rsp_register_select,
   output logic [3:0]                           rsp_nibble,
   output logic [clns_pkg::TimeWidth-1:0]       rsp_pulse_us,
   output logic [clns_pkg::TimeWidth-1:0]       rsp_wait_after_us,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [clns_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [clns_pkg::TimeWidth-1:0]       csr_wdata
);

   logic [clns_pkg::TimeWidth-1:0] command_pulse_ff, command_pulse_in;
   logic [clns_pkg::TimeWidth-1:0] data_pulse_ff, data_pulse_in;
   logic                           q_full;
   logic                           q_push;
   logic                           q_pop;
   logic                           q_valid;
   clns_pkg::desc_type             q_wdata;
   clns_pkg::desc_type             q_rdata;

   // Pulse width registers; writes to other indexes are ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      command_pulse_in = command_pulse_ff;
      data_pulse_in    = data_pulse_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            clns_pkg::CsrCommandPulse: command_pulse_in = csr_wdata;
            clns_pkg::CsrDataPulse:    data_pulse_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         command_pulse_ff <= clns_pkg::CommandPulseReset;
         data_pulse_ff    <= clns_pkg::DataPulseReset;
      end else begin
         command_pulse_ff <= command_pulse_in;
         data_pulse_ff    <= data_pulse_in;
      end
   end

   clns_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_byte_value (req_byte_value),
      .req_row        (req_row),
      .req_column     (req_column),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_wdata        (q_wdata)
   );

   clns_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .full   (q_full),
      .pop    (q_pop),
      .rvalid (q_valid),
      .rdata  (q_rdata)
   );

   clns_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_rdata             (q_rdata),
      .q_pop               (q_pop),
      .command_pulse_us    (command_pulse_ff),
      .data_pulse_us       (data_pulse_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_wait_before_us  (rsp_wait_before_us),
      .rsp_register_select (rsp_register_select),
      .rsp_nibble          (rsp_nibble),
      .rsp_pulse_us        (rsp_pulse_us),
      .rsp_wait_after_us   (rsp_wait_after_us),
      .rsp_last            (rsp_last)
   );

endmodule

[sim/char_lcd_nibble_sequencer_top_tb.sv]
// Self-checking testbench for char_lcd_nibble_sequencer_top: directed and random requests,
// pulse width register writes and an in-bench predictor of every enable pulse beat.
// Depends on clns_pkg and the char_lcd_nibble_sequencer_top RTL.
module char_lcd_nibble_sequencer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Cursor rows that select a display line.
   localparam logic [7:0] RowTop    = 8'd1;
   localparam logic [7:0] RowBottom = 8'd2;

   // Register indexes that have no register behind them.
   localparam logic [clns_pkg::CsrIdxWidth-1:0] CsrSpareLo = 2'd2;
   localparam logic [clns_pkg::CsrIdxWidth-1:0] CsrSpareHi = 2'd3;

   // Largest value a pulse width register can hold.
   localparam logic [clns_pkg::TimeWidth-1:0] TimeMax = '1;

   // Command bytes of the power-on init run, sent in this order.
   localparam logic [7:0] PowerOnBytes [8] =
      '{8'h03, 8'h03, 8'h03, 8'h02, 8'h28, 8'h0C, 8'h06, 8'h01};

   localparam int IdleTailCycles = 16;
   localparam int StallLimit     = 1000;
   localparam int ItemsPerPhase  = 50;

   typedef struct packed {
      logic [clns_pkg::KindWidth-1:0] kind;
      logic [7:0]                     byte_value;
      logic [7:0]                     row;
      logic [7:0]                     column;
   } lcd_request_type;

   typedef struct packed {
      logic [clns_pkg::TimeWidth-1:0] wait_before_us;
      logic                           register_select;
      logic [3:0]                     nibble;
      logic [clns_pkg::TimeWidth-1:0] pulse_us;
      logic [clns_pkg::TimeWidth-1:0] wait_after_us;
      logic                           last;
   } lcd_pulse_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [clns_pkg::KindWidth-1:0]   req_kind = '0;
   logic [7:0]                       req_byte_value = '0;
   logic [7:0]                       req_row = '0;
   logic [7:0]                       req_column = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [clns_pkg::TimeWidth-1:0]   rsp_wait_before_us;
   logic                             rsp_register_select;
   logic [3:0]                       rsp_nibble;
   logic [clns_pkg::TimeWidth-1:0]   rsp_pulse_us;
   logic [clns_pkg::TimeWidth-1:0]   rsp_wait_after_us;
   logic                             rsp_last;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [clns_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [clns_pkg::TimeWidth-1:0]   csr_wdata = '0;

   // Predictor state: the two pulse widths and the pulses still to come.
   logic [clns_pkg::TimeWidth-1:0] command_width_us = clns_pkg::CommandPulseReset;
   logic [clns_pkg::TimeWidth-1:0] char_width_us    = clns_pkg::DataPulseReset;
   lcd_pulse_type                  pulses_due [$];
   int                             failures = 0;
   bit                             req_idle_on = 1'b1;
   bit                             rsp_idle_on = 1'b1;
   int unsigned                    rsp_hold = 0;
   int                             quiet_cycles = 0;

   char_lcd_nibble_sequencer_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_byte_value      (req_byte_value),
      .req_row             (req_row),
      .req_column          (req_column),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_wait_before_us  (rsp_wait_before_us),
      .rsp_register_select (rsp_register_select),
      .rsp_nibble          (rsp_nibble),
      .rsp_pulse_us        (rsp_pulse_us),
      .rsp_wait_after_us   (rsp_wait_after_us),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // Free-running clock.
   initial begin
      forever #1 clock = ~clock;
   end

   // Gap length: mostly short, now and then a long one.
   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 15) == 0)
         return $urandom_range(20, 50);
      return $urandom_range(1, 4);
   endfunction

   // Queues the two pulses of one byte, high nibble first.
   function automatic void expect_byte(input logic is_data, input logic [7:0] value,
                                       input logic [clns_pkg::TimeWidth-1:0] wait_before,
                                       input logic [clns_pkg::TimeWidth-1:0] wait_after,
                                       input logic last);
      lcd_pulse_type p;
      p.wait_before_us  = wait_before;
      p.register_select = is_data;
      p.nibble          = value[7:4];
      p.pulse_us        = is_data ? char_width_us : command_width_us;
      p.wait_after_us   = '0;
      p.last            = 1'b0;
      pulses_due.push_back(p);
      p.wait_before_us  = '0;
      p.nibble          = value[3:0];
      p.wait_after_us   = wait_after;
      p.last            = last;
      pulses_due.push_back(p);
   endfunction

   // Works out every pulse that one accepted request causes.
   function automatic void expect_pulses(input lcd_request_type r);
      logic [7:0]                     address;
      logic [clns_pkg::TimeWidth-1:0] lead;
      logic [clns_pkg::TimeWidth-1:0] settle;
      case (r.kind)
         clns_pkg::KindCommand: expect_byte(1'b0, r.byte_value, '0, '0, 1'b1);
         clns_pkg::KindData: expect_byte(1'b1, r.byte_value, '0, '0, 1'b1);
         clns_pkg::KindCursor: begin
            // The address wraps to eight bits; rows other than the two lines go home.
            if (r.row == RowTop)
               address = clns_pkg::CmdLine1Base + r.column - 8'd1;
            else if (r.row == RowBottom)
               address = clns_pkg::CmdLine2Base + r.column - 8'd1;
            else
               address = clns_pkg::CmdLine1Base;
            expect_byte(1'b0, address, '0, '0, 1'b1);
         end
         clns_pkg::KindInit: begin
            for (int i = 0; i < 8; i++) begin
               lead = (i == 0) ? clns_pkg::InitLeadUs : '0;
               if (i == 0)
                  settle = clns_pkg::SettleFirstUs;
               else if (i == 1)
                  settle = clns_pkg::SettleSecondUs;
               else if (i == 7)
                  settle = clns_pkg::ClearSettleUs;
               else
                  settle = '0;
               expect_byte(1'b0, PowerOnBytes[i], lead, settle, i == 7);
            end
         end
         clns_pkg::KindClear:
            expect_byte(1'b0, clns_pkg::CmdClear, '0, clns_pkg::ClearSettleUs, 1'b1);
         default: ;
      endcase
   endfunction

   // Sends one request beat and predicts its pulses once it is taken.
   task automatic send_request(input lcd_request_type r);
      int unsigned gap;
      gap = (req_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_kind       = r.kind;
      req_byte_value = r.byte_value;
      req_row        = r.row;
      req_column     = r.column;
      do @(posedge clock); while (req_stall);
      expect_pulses(r);
   endtask

   // Writes one register beat and mirrors the write in the predictor.
   task automatic write_register(input logic [clns_pkg::CsrIdxWidth-1:0] idx,
                                 input logic [clns_pkg::TimeWidth-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      if (idx == clns_pkg::CsrCommandPulse)
         command_width_us = value;
      else if (idx == clns_pkg::CsrDataPulse)
         char_width_us = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Stops sending, waits for every pending pulse and lets the block drain.
   task automatic settle_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pulses_due.size() != 0) @(posedge clock);
      repeat (IdleTailCycles) @(posedge clock);
   endtask

   function automatic lcd_request_type make_request(
                                                 input logic [clns_pkg::KindWidth-1:0] kind,
                                                 input logic [7:0] value,
                                                 input logic [7:0] row,
                                                 input logic [7:0] column);
      lcd_request_type r;
      r.kind       = kind;
      r.byte_value = value;
      r.row        = row;
      r.column     = column;
      return r;
   endfunction

   // Random request: mostly bytes and cursor moves, some init and clear, a few bad kinds.
   function automatic lcd_request_type random_request();
      lcd_request_type r;
      int unsigned     roll;
      roll         = $urandom_range(0, 99);
      r.byte_value = 8'($urandom);
      r.row        = 8'($urandom);
      r.column     = 8'($urandom);
      if (roll < 30)
         r.kind = clns_pkg::KindCommand;
      else if (roll < 58)
         r.kind = clns_pkg::KindData;
      else if (roll < 80)
         r.kind = clns_pkg::KindCursor;
      else if (roll < 85)
         r.kind = clns_pkg::KindInit;
      else if (roll < 94)
         r.kind = clns_pkg::KindClear;
      else
         r.kind = clns_pkg::KindWidth'($urandom_range(int'(clns_pkg::KindClear) + 1,
                                                      (1 << clns_pkg::KindWidth) - 1));
      if (r.kind == clns_pkg::KindCursor && $urandom_range(0, 4) != 0)
         r.row = $urandom_range(0, 1) ? RowTop : RowBottom;
      return r;
   endfunction

   // Command and character bytes at their extremes, with the reset pulse widths.
   task automatic test_byte_requests();
      send_request(make_request(clns_pkg::KindCommand, 8'h00, 8'h00, 8'h00));
      send_request(make_request(clns_pkg::KindCommand, 8'hFF, 8'hFF, 8'hFF));
      send_request(make_request(clns_pkg::KindCommand, 8'hA5, 8'h00, 8'h00));
      send_request(make_request(clns_pkg::KindData, 8'h00, 8'hFF, 8'h00));
      send_request(make_request(clns_pkg::KindData, 8'hFF, 8'h00, 8'hFF));
      send_request(make_request(clns_pkg::KindData, 8'h5A, 8'h00, 8'h00));
      settle_idle();
   endtask

   // Cursor moves on both lines, wrapping columns and rows that fall back to home.
   task automatic test_cursor_moves();
      send_request(make_request(clns_pkg::KindCursor, 8'h00, RowTop, 8'd1));
      send_request(make_request(clns_pkg::KindCursor, 8'hFF, RowTop, 8'd0));
      send_request(make_request(clns_pkg::KindCursor, 8'h00, RowBottom, 8'd255));
      send_request(make_request(clns_pkg::KindCursor, 8'h00, RowBottom, 8'd64));
      send_request(make_request(clns_pkg::KindCursor, 8'h00, 8'd0, 8'd10));
      send_request(make_request(clns_pkg::KindCursor, 8'h00, 8'd3, 8'd1));
      send_request(make_request(clns_pkg::KindCursor, 8'h00, 8'd255, 8'd255));
      settle_idle();
   endtask

   // The full power-on run and a clear.
   task automatic test_init_and_clear();
      send_request(make_request(clns_pkg::KindInit, 8'hFF, 8'hFF, 8'hFF));
      send_request(make_request(clns_pkg::KindClear, 8'h00, 8'h00, 8'h00));
      settle_idle();
   endtask

   // Unknown kinds cause no pulses; a command afterwards proves nothing leaked out.
   task automatic test_unknown_kinds();
      for (int k = int'(clns_pkg::KindClear) + 1; k < (1 << clns_pkg::KindWidth); k++)
         send_request(make_request(clns_pkg::KindWidth'(k), 8'($urandom), 8'($urandom),
                                   8'($urandom)));
      send_request(make_request(clns_pkg::KindCommand, 8'h3C, 8'h00, 8'h00));
      settle_idle();
   endtask

   // Writes to spare indexes are dropped; widths of zero and all ones are used as written.
   task automatic test_register_writes();
      write_register(CsrSpareLo, '0);
      write_register(CsrSpareHi, TimeMax);
      send_request(make_request(clns_pkg::KindData, 8'h41, 8'h00, 8'h00));
      settle_idle();
      write_register(clns_pkg::CsrCommandPulse, '0);
      write_register(clns_pkg::CsrDataPulse, TimeMax);
      send_request(make_request(clns_pkg::KindCommand, 8'h0F, 8'h00, 8'h00));
      send_request(make_request(clns_pkg::KindData, 8'hF0, 8'h00, 8'h00));
      settle_idle();
      write_register(clns_pkg::CsrCommandPulse, TimeMax);
      write_register(clns_pkg::CsrDataPulse, '0);
      send_request(make_request(clns_pkg::KindClear, 8'h00, 8'h00, 8'h00));
      send_request(make_request(clns_pkg::KindData, 8'h7E, 8'h00, 8'h00));
      settle_idle();
   endtask

   // Random traffic in phases, each with its own pulse widths; later phases add idling.
   task automatic test_random_traffic();
      logic [clns_pkg::TimeWidth-1:0] widths [6][2];
      lcd_request_type                r;
      int                             sent;
      widths = '{'{clns_pkg::CommandPulseReset, clns_pkg::DataPulseReset},
                 '{15'd1, 15'd1}, '{15'd20000, 15'd20000}, '{'0, TimeMax},
                 '{TimeMax, '0}, '{15'd0, 15'd0}};
      widths[5][0] = clns_pkg::TimeWidth'($urandom);
      widths[5][1] = clns_pkg::TimeWidth'($urandom);
      for (int phase = 0; phase < 6; phase++) begin
         settle_idle();
         write_register(clns_pkg::CsrCommandPulse, widths[phase][0]);
         write_register(clns_pkg::CsrDataPulse, widths[phase][1]);
         req_idle_on = (phase >= 2);
         rsp_idle_on = (phase >= 1);
         sent = 0;
         while (sent < ItemsPerPhase) begin
            r = random_request();
            send_request(r);
            if (r.kind <= clns_pkg::KindClear)
               sent++;
         end
      end
      settle_idle();
   endtask

   // Result side stall: random gaps, switched off for the quiet phase.
   always @(negedge clock) begin
      if (!rsp_idle_on) begin
         rsp_hold = 0;
         rsp_stall <= 1'b0;
      end else if (rsp_hold != 0) begin
         rsp_hold = rsp_hold - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_hold = pick_gap() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void check_field(input string name, input int unsigned expected,
                                       input int unsigned actual);
      if (expected != actual) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         failures++;
      end
   endfunction

   // Compares each pulse beat with the oldest pending one.
   always @(posedge clock) begin
      lcd_pulse_type p;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pulses_due.size() == 0) begin
            $error("rsp beat with no pending pulse: nibble %0d", rsp_nibble);
            failures++;
         end else begin
            p = pulses_due.pop_front();
            check_field("wait_before_us", 32'(p.wait_before_us), 32'(rsp_wait_before_us));
            check_field("register_select", 32'(p.register_select),
                        32'(rsp_register_select));
            check_field("nibble", 32'(p.nibble), 32'(rsp_nibble));
            check_field("pulse_us", 32'(p.pulse_us), 32'(rsp_pulse_us));
            check_field("wait_after_us", 32'(p.wait_after_us), 32'(rsp_wait_after_us));
            check_field("last", 32'(p.last), 32'(rsp_last));
         end
      end
   end

   // Watchdog: too long without any beat on any channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("** char_lcd_nibble_sequencer_top: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Test sequence.
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_byte_requests();
      test_cursor_moves();
      test_init_and_clear();
      test_unknown_kinds();
      test_register_writes();
      test_random_traffic();
      if (failures == 0)
         $display("** char_lcd_nibble_sequencer_top: PASSED **");
      else
         $display("** char_lcd_nibble_sequencer_top: FAILED **");
      $finish;
   end

endmodule
